[hw/rtl/trpd_pkg.sv]
// ----------------------------------------------------------------------------
// trpd_pkg
// Shared types and constants of the TGA run-length pixel decoder.
// ----------------------------------------------------------------------------
package trpd_pkg;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_COLUMNS   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RLE_MODE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HAS_ALPHA = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TOP_DOWN  = 3'd4;

	localparam int FIELD_W = 16;
	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
	localparam int MIN_COLUMNS = 4;

	// packet phase of the run-length stream
	typedef enum logic [1:0] {
		PH_HEADER,
		PH_RUN,
		PH_LITERAL
	} phase_t;

	// sequencer of the span loop
	typedef enum logic [1:0] {
		S_IDLE,
		S_PREP,
		S_EMIT
	} seq_state_t;

	// result of the span unit for the current span
	typedef struct packed {
		logic [7:0] take;
		logic       row_end;
		logic       img_end;
	} span_status_t;

endpackage

[hw/rtl/trpd_span_unit.sv]
// ----------------------------------------------------------------------------
// trpd_span_unit
// Span arithmetic shared by every span: room left in the row, output row
// mapping and last-row test, registered, then span length and row end.
// ----------------------------------------------------------------------------
module trpd_span_unit #(
	parameter int DIM_BITS = 16
) (
	input  logic                    clk,
	input  logic                    prep,
	input  logic [DIM_BITS-1:0]     cols,
	input  logic [DIM_BITS-1:0]     rows,
	input  logic                    top_down,
	input  logic [DIM_BITS-1:0]     file_row,
	input  logic [DIM_BITS-1:0]     cur_col,
	input  logic [7:0]              count,
	output logic [DIM_BITS-1:0]     orow,
	output trpd_pkg::span_status_t  status
);
	import trpd_pkg::*;

	logic [DIM_BITS-1:0] space_s1;
	logic [DIM_BITS-1:0] orow_s1;
	logic                last_row_s1;
	logic [DIM_BITS-1:0] space_d;
	logic [DIM_BITS-1:0] orow_d;
	logic                last_row_d;
	logic                row_end;

	always_comb begin
		space_d = (cur_col < cols) ? (cols - cur_col) : DIM_BITS'(1);
		if (top_down) begin
			orow_d = file_row;
		end else if (file_row < rows) begin
			orow_d = rows - DIM_BITS'(1) - file_row;
		end else begin
			orow_d = '0;
		end
		last_row_d = (({1'b0, file_row} + (DIM_BITS+1)'(1)) >= {1'b0, rows});
	end

	always_ff @(posedge clk) begin
		if (prep) begin
			space_s1    <= space_d;
			orow_s1     <= orow_d;
			last_row_s1 <= last_row_d;
		end
	end

	// a span that fills the rest of the row is never longer than the count
	assign row_end        = (DIM_BITS'(count) >= space_s1);
	assign status.take    = row_end ? space_s1[7:0] : count;
	assign status.row_end = row_end;
	assign status.img_end = last_row_s1;
	assign orow           = orow_s1;

endmodule

[hw/rtl/tga_rle_pixel_decoder.sv]
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder
// TGA pixel-data decoder for uncompressed and run-length images, emitting
// single-colour spans that never cross a row end.
// ----------------------------------------------------------------------------
// One pixel-data byte is taken per cycle while the decoder is idle. Header
// bytes and bytes inside a pixel produce nothing. The byte that completes a
// pixel starts the span loop: every span passes through the shared span unit
// in a prepare state, then an emit state into the output register, and the
// byte input stays held off until the last span of the byte is emitted, also
// while the span output stalls. A run crossing many rows gives one span per
// row touched. Once the final pixel of the image is placed, all further bytes
// are taken and dropped until reset. Register writes are taken only while
// idle. Image widths below 4 behave as 4 and a height of 0 as 1.
module tga_rle_pixel_decoder #(
	parameter int DIM_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration writes
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [trpd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [trpd_pkg::FIELD_W-1:0]     cfg_data,
	// pixel-data bytes
	input  logic                             byte_valid,
	output logic                             byte_stall,
	input  logic [7:0]                       data_byte,
	// spans
	output logic                             span_valid,
	input  logic                             span_stall,
	output logic [trpd_pkg::FIELD_W-1:0]     out_row,
	output logic [trpd_pkg::FIELD_W-1:0]     start_column,
	output logic [7:0]                       span_length,
	output logic [7:0]                       blue,
	output logic [7:0]                       green,
	output logic [7:0]                       red,
	output logic [7:0]                       alpha,
	output logic                             image_done,
	output logic                             last_of_input
);
	import trpd_pkg::*;

	// configuration registers
	logic [DIM_BITS-1:0] cols_q;
	logic [DIM_BITS-1:0] rows_q;
	logic                rle_q;
	logic                alpha_en_q;
	logic                top_down_q;
	logic [DIM_BITS-1:0] cols_eff;
	logic [DIM_BITS-1:0] rows_eff;

	// stream state
	seq_state_t          state_q, state_d;
	phase_t              phase_q;
	logic [1:0]          bip_q;
	logic [7:0]          packet_left_q;
	logic [7:0]          blue_q, green_q, red_q, alpha_q;
	logic [DIM_BITS-1:0] file_row_q;
	logic [DIM_BITS-1:0] cur_col_q;
	logic                finished_q;
	logic [7:0]          count_q;

	// output register
	logic                span_valid_q;
	logic [DIM_BITS-1:0] out_row_q;
	logic [DIM_BITS-1:0] start_col_q;
	logic [7:0]          span_len_q;
	logic [7:0]          blue_o_q, green_o_q, red_o_q, alpha_o_q;
	logic                done_q;
	logic                last_q;

	// control
	logic                cfg_fire;
	logic                byte_fire;
	logic [1:0]          last_index;
	logic                hdr_byte;
	logic                pix_done;
	logic [7:0]          pix_count;
	logic [7:0]          pl_dec;
	logic                start_place;
	logic                out_free;
	logic                prep_en;
	logic                emit;
	logic [7:0]          rem;
	logic                span_last;
	logic [DIM_BITS-1:0] orow;
	span_status_t        st;

	// --------------------------------------------------------------------
	// configuration
	// --------------------------------------------------------------------
	assign cfg_fire = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q     <= DIM_BITS'(MIN_COLUMNS);
			rows_q     <= DIM_BITS'(1);
			rle_q      <= 1'b0;
			alpha_en_q <= 1'b0;
			top_down_q <= 1'b0;
		end else if (cfg_fire) begin
			unique case (cfg_index)
				REG_COLUMNS:   cols_q     <= cfg_data[DIM_BITS-1:0];
				REG_ROWS:      rows_q     <= cfg_data[DIM_BITS-1:0];
				REG_RLE_MODE:  rle_q      <= cfg_data[0];
				REG_HAS_ALPHA: alpha_en_q <= cfg_data[0];
				REG_TOP_DOWN:  top_down_q <= cfg_data[0];
				default: ; // unknown index, write dropped
			endcase
		end
	end

	// narrow widths and empty heights are clamped
	assign cols_eff = (cols_q < DIM_BITS'(MIN_COLUMNS)) ? DIM_BITS'(MIN_COLUMNS) : cols_q;
	assign rows_eff = (rows_q == '0) ? DIM_BITS'(1) : rows_q;

	// --------------------------------------------------------------------
	// byte decode
	// --------------------------------------------------------------------
	assign byte_fire  = byte_valid && !byte_stall;
	assign last_index = alpha_en_q ? 2'd3 : 2'd2;
	// a packet header is expected only in run-length mode
	assign hdr_byte   = rle_q && (phase_q == PH_HEADER);
	// a count already past the pixel size completes on this byte
	assign pix_done   = !hdr_byte && (bip_q >= last_index);
	assign pl_dec     = (packet_left_q != 8'd0) ? (packet_left_q - 8'd1) : 8'd0;

	always_comb begin
		if (rle_q && (phase_q == PH_RUN)) begin
			pix_count = packet_left_q;
		end else begin
			pix_count = 8'd1;
		end
	end

	assign start_place = byte_fire && !finished_q && pix_done && (pix_count != 8'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_HEADER;
			bip_q         <= 2'd0;
			packet_left_q <= 8'd0;
			blue_q        <= 8'd0;
			green_q       <= 8'd0;
			red_q         <= 8'd0;
			alpha_q       <= ALPHA_OPAQUE;
		end else if (byte_fire && !finished_q) begin
			if (hdr_byte) begin
				packet_left_q <= {1'b0, data_byte[6:0]} + 8'd1;
				phase_q       <= data_byte[7] ? PH_RUN : PH_LITERAL;
				bip_q         <= 2'd0;
			end else begin
				// colour bytes arrive blue, green, red; a fourth is alpha
				unique case (bip_q)
					2'd0: blue_q  <= data_byte;
					2'd1: green_q <= data_byte;
					2'd2: red_q   <= data_byte;
					default: ;
				endcase
				if (!pix_done) begin
					bip_q <= bip_q + 2'd1;
				end else begin
					bip_q   <= 2'd0;
					alpha_q <= alpha_en_q ? data_byte : ALPHA_OPAQUE;
					// uncompressed mode leaves the packet state alone
					if (rle_q) begin
						if (phase_q == PH_RUN) begin
							packet_left_q <= 8'd0;
							phase_q       <= PH_HEADER;
						end else begin
							packet_left_q <= pl_dec;
							if (pl_dec == 8'd0) begin
								phase_q <= PH_HEADER;
							end
						end
					end
				end
			end
		end
	end

	// --------------------------------------------------------------------
	// span loop sequencer
	// --------------------------------------------------------------------
	assign out_free  = !span_valid_q || !span_stall;
	assign rem       = count_q - st.take;
	assign span_last = (rem == 8'd0) || (st.row_end && st.img_end);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start_place) begin
					state_d = S_PREP;
				end
			end
			S_PREP: begin
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (out_free) begin
					state_d = span_last ? S_IDLE : S_PREP;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		byte_stall = (state_q != S_IDLE);
		cfg_ready  = (state_q == S_IDLE);
		prep_en    = (state_q == S_PREP);
		emit       = (state_q == S_EMIT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	trpd_span_unit #(
		.DIM_BITS (DIM_BITS)
	) u_span (
		.clk      (clk),
		.prep     (prep_en),
		.cols     (cols_eff),
		.rows     (rows_eff),
		.top_down (top_down_q),
		.file_row (file_row_q),
		.cur_col  (cur_col_q),
		.count    (count_q),
		.orow     (orow),
		.status   (st)
	);

	// position in the image advances by one span per emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= 8'd0;
			file_row_q <= '0;
			cur_col_q  <= '0;
			finished_q <= 1'b0;
		end else if (start_place) begin
			count_q <= pix_count;
		end else if (emit) begin
			count_q <= rem;
			if (st.row_end) begin
				cur_col_q <= '0;
				if (st.img_end) begin
					finished_q <= 1'b1;
				end else begin
					file_row_q <= file_row_q + DIM_BITS'(1);
				end
			end else begin
				cur_col_q <= cur_col_q + DIM_BITS'(st.take);
			end
		end
	end

	// --------------------------------------------------------------------
	// output register, holds a span until its transfer
	// --------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_valid_q <= 1'b0;
		end else if (emit) begin
			span_valid_q <= 1'b1;
		end else if (!span_stall) begin
			span_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_row_q   <= orow;
			start_col_q <= cur_col_q;
			span_len_q  <= st.take;
			blue_o_q    <= blue_q;
			green_o_q   <= green_q;
			red_o_q     <= red_q;
			alpha_o_q   <= alpha_q;
			done_q      <= st.row_end && st.img_end;
			last_q      <= span_last;
		end
	end

	assign span_valid    = span_valid_q;
	assign out_row       = FIELD_W'(out_row_q);
	assign start_column  = FIELD_W'(start_col_q);
	assign span_length   = span_len_q;
	assign blue          = blue_o_q;
	assign green         = green_o_q;
	assign red           = red_o_q;
	assign alpha         = alpha_o_q;
	assign image_done    = done_q;
	assign last_of_input = last_q;

endmodule

[hw/rtl/trpd_checker.sv]
// ----------------------------------------------------------------------------
// trpd_checker
// Port-level checks of the TGA run-length pixel decoder, bound to the top.
// ----------------------------------------------------------------------------
module trpd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        byte_stall,
	input logic        span_valid,
	input logic        span_stall,
	input logic [15:0] out_row,
	input logic [15:0] start_column,
	input logic [7:0]  span_length,
	input logic        image_done,
	input logic        last_of_input
);

	// a span is never empty and never longer than one packet
	a_span_len: assert property (@(posedge clk) disable iff (!arst_n)
		span_valid |-> (span_length != 8'd0) && (span_length <= 8'd128))
		else $error("span length out of range");

	// the final span of the image always ends the byte's spans
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		span_valid && image_done |-> last_of_input)
		else $error("image done without last of input");

	// more spans pending for this byte keep the byte input held off
	a_hold_input: assert property (@(posedge clk) disable iff (!arst_n)
		span_valid && !last_of_input |-> byte_stall)
		else $error("byte input open while spans pending");

	// a stalled span keeps its position
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		span_valid && span_stall |=> span_valid && $stable(out_row)
			&& $stable(start_column) && $stable(span_length))
		else $error("stalled span changed");

endmodule

bind tga_rle_pixel_decoder trpd_checker u_trpd_checker (.*);

[test/tga_span_checker.sv]
// ----------------------------------------------------------------------------
// tga_span_checker
// Watches the byte, span and register channels of the TGA pixel decoder,
// decodes the accepted bytes on its own and compares every span it sees.
// ----------------------------------------------------------------------------
module tga_span_checker #(
	parameter int DIM_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [trpd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [trpd_pkg::FIELD_W-1:0]   cfg_data,
	input  logic                           byte_valid,
	input  logic                           byte_stall,
	input  logic [7:0]                     data_byte,
	input  logic                           span_valid,
	input  logic                           span_stall,
	input  logic [trpd_pkg::FIELD_W-1:0]   out_row,
	input  logic [trpd_pkg::FIELD_W-1:0]   start_column,
	input  logic [7:0]                     span_length,
	input  logic [7:0]                     blue,
	input  logic [7:0]                     green,
	input  logic [7:0]                     red,
	input  logic [7:0]                     alpha,
	input  logic                           image_done,
	input  logic                           last_of_input,
	output int                             mismatch_count,
	output int                             spans_waiting,
	output int                             spans_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	import trpd_pkg::*;

	localparam logic [15:0] DIM_MASK = 16'((32'd1 << DIM_BITS) - 32'd1);

	typedef struct packed {
		logic [15:0] row;
		logic [15:0] col;
		logic [7:0]  len;
		logic [7:0]  b;
		logic [7:0]  g;
		logic [7:0]  r;
		logic [7:0]  a;
		logic        done;
		logic        last;
	} span_t;

	span_t pending_spans[$];

	logic [15:0] cols_r, rows_r;
	logic        rle_r, alpha_r, top_r;
	phase_t      ph;
	logic [1:0]  bip;
	logic [7:0]  packet_left;
	logic [23:0] pix;
	logic [15:0] file_row, cur_col;
	logic        img_done;

	task automatic flag_mismatch(input string field, input int unsigned got,
			input int unsigned want);
		if (mismatch_count < 64)
			$display("mismatch on span %0d, %s: got 0x%0h, want 0x%0h",
				spans_checked, field, got, want);
		mismatch_count++;
	endtask

	task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		case (idx)
			REG_COLUMNS:   cols_r = val & DIM_MASK;
			REG_ROWS:      rows_r = val & DIM_MASK;
			REG_RLE_MODE:  rle_r = val[0];
			REG_HAS_ALPHA: alpha_r = val[0];
			REG_TOP_DOWN:  top_r = val[0];
			default: ;
		endcase
	endtask

	// spread count pixels of one colour over rows, one span per row piece
	task automatic lay_spans(input int unsigned count, input logic [7:0] bl,
			input logic [7:0] gr, input logic [7:0] rd, input logic [7:0] al);
		int unsigned ncols, nrows, space, take, col;
		span_t s;
		ncols = (cols_r < MIN_COLUMNS) ? MIN_COLUMNS : cols_r;
		nrows = (rows_r == 16'd0) ? 1 : rows_r;
		while (count != 0 && !img_done) begin
			col = cur_col;
			space = (col < ncols) ? ncols - col : 1;
			take = (count < space) ? count : space;
			if (top_r)
				s.row = file_row;
			else
				s.row = (file_row < nrows) ? 16'(nrows - 1 - file_row) : 16'd0;
			s.col = cur_col;
			s.len = 8'(take);
			s.b = bl;
			s.g = gr;
			s.r = rd;
			s.a = al;
			s.done = 1'b0;
			s.last = 1'b0;
			col += take;
			count -= take;
			if (col >= ncols) begin
				col = 0;
				if (file_row + 1 >= nrows) begin
					img_done = 1'b1;
					s.done = 1'b1;
				end else begin
					file_row = file_row + 16'd1;
				end
			end
			cur_col = 16'(col);
			pending_spans.push_back(s);
		end
	endtask

	task automatic decode_byte(input logic [7:0] b);
		logic [1:0] last_idx;
		logic [7:0] al;
		int n_prior;
		span_t tail;
		last_idx = alpha_r ? 2'd3 : 2'd2;
		if (img_done)
			return;
		// packet header in run-length mode
		if (rle_r && ph == PH_HEADER) begin
			packet_left = {1'b0, b[6:0]} + 8'd1;
			ph = b[7] ? PH_RUN : PH_LITERAL;
			bip = 2'd0;
			return;
		end
		// the fourth byte is alpha and is never stored
		if (bip != 2'd3)
			pix[8*bip +: 8] = b;
		if (bip < last_idx) begin
			bip = bip + 2'd1;
			return;
		end
		al = alpha_r ? b : ALPHA_OPAQUE;
		bip = 2'd0;
		n_prior = pending_spans.size();
		if (!rle_r) begin
			lay_spans(1, pix[7:0], pix[15:8], pix[23:16], al);
		end else if (ph == PH_RUN) begin
			lay_spans(packet_left, pix[7:0], pix[15:8], pix[23:16], al);
			packet_left = 8'd0;
			ph = PH_HEADER;
		end else begin
			lay_spans(1, pix[7:0], pix[15:8], pix[23:16], al);
			if (packet_left != 8'd0)
				packet_left = packet_left - 8'd1;
			if (packet_left == 8'd0)
				ph = PH_HEADER;
		end
		if (pending_spans.size() > n_prior) begin
			tail = pending_spans.pop_back();
			tail.last = 1'b1;
			pending_spans.push_back(tail);
		end
	endtask

	task automatic check_span();
		span_t want;
		if (pending_spans.size() == 0) begin
			flag_mismatch("span with nothing waiting, out_row", out_row, 0);
			return;
		end
		want = pending_spans.pop_front();
		if (out_row !== want.row)
			flag_mismatch("out_row", out_row, want.row);
		if (start_column !== want.col)
			flag_mismatch("start_column", start_column, want.col);
		if (span_length !== want.len)
			flag_mismatch("span_length", span_length, want.len);
		if (blue !== want.b)
			flag_mismatch("blue", blue, want.b);
		if (green !== want.g)
			flag_mismatch("green", green, want.g);
		if (red !== want.r)
			flag_mismatch("red", red, want.r);
		if (alpha !== want.a)
			flag_mismatch("alpha", alpha, want.a);
		if (image_done !== want.done)
			flag_mismatch("image_done", image_done, want.done);
		if (last_of_input !== want.last)
			flag_mismatch("last_of_input", last_of_input, want.last);
		spans_checked++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_r = 16'd4;
			rows_r = 16'd1;
			rle_r = 1'b0;
			alpha_r = 1'b0;
			top_r = 1'b0;
			ph = PH_HEADER;
			bip = 2'd0;
			packet_left = 8'd0;
			pix = 24'd0;
			file_row = 16'd0;
			cur_col = 16'd0;
			img_done = 1'b0;
			pending_spans.delete();
			mismatch_count = 0;
			spans_waiting = 0;
			spans_checked = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				apply_reg(cfg_index, cfg_data);
			// retire first: a span never comes from the byte taken at this edge
			if (span_valid && !span_stall)
				check_span();
			if (byte_valid && !byte_stall)
				decode_byte(data_byte);
			spans_waiting = pending_spans.size();
		end
	end

endmodule

[test/tga_rle_pixel_decoder_tb.sv]
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder_tb
// Feeds pixel-data byte streams to the TGA decoder under changing image
// settings and random flow control; a checker beside the block scores spans.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import trpd_pkg::*;

	localparam int QUIET_LIMIT = 2000; // cycles with no transfer on any channel
	localparam int SETTLE      = 8;    // idle cycles before a register write
	localparam int DRAIN       = 40;   // cycles after the last span
	localparam int RAND_PHASES = 8;
	localparam int PHASE_BYTES = 12;

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	typedef struct {
		logic [CFG_IDX_W-1:0] idx;
		logic [FIELD_W-1:0]   val;
	} reg_write_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [FIELD_W-1:0]   cfg_data = '0;
	logic                 byte_valid = 1'b0;
	logic                 byte_stall;
	logic [7:0]           data_byte = 8'd0;
	logic                 span_valid;
	logic                 span_stall = 1'b0;
	logic [FIELD_W-1:0]   out_row;
	logic [FIELD_W-1:0]   start_column;
	logic [7:0]           span_length;
	logic [7:0]           blue;
	logic [7:0]           green;
	logic [7:0]           red;
	logic [7:0]           alpha;
	logic                 image_done;
	logic                 last_of_input;

	int mismatch_count;
	int spans_waiting;
	int spans_checked;

	// stimulus bookkeeping
	int         send_pct = 0;
	int         stall_pct = 0;
	int         bytes_sent = 0;
	int         regs_written = 0;
	int         quiet = 0;
	logic       rle_now = 1'b0;
	logic       alpha_now = 1'b0;
	reg_write_t reg_batch[$];

	tga_rle_pixel_decoder dut (.*);

	tga_span_checker span_chk (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// span receiver: random stall, one decision per cycle
	always @(posedge clk)
		span_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);

	// watchdog on any transfer at all
	always @(posedge clk) begin
		if (!arst_n || (byte_valid && !byte_stall) || (span_valid && !span_stall)
				|| (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("no transfer for %0d cycles", QUIET_LIMIT);
			$display("FAILED: results differ");
			$finish;
		end
	end

	task automatic set_idling(input idle_mode_t mode);
		case (mode)
			IDLE_NONE:     begin send_pct = 0;  stall_pct = 0;  end
			IDLE_SENDER:   begin send_pct = 54; stall_pct = 0;  end
			IDLE_RECEIVER: begin send_pct = 0;  stall_pct = 54; end
			default:       begin send_pct = 24; stall_pct = 24; end
		endcase
	endtask

	// leaves the caller at a rising edge, right after the transfer
	task automatic send_byte(input logic [7:0] b);
		while (send_pct != 0 && $urandom_range(0, 99) < send_pct) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		data_byte <= b;
		do @(negedge clk); while (byte_stall);
		@(posedge clk);
		bytes_sent++;
	endtask

	function automatic logic [7:0] rand_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic queue_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		reg_write_t w;
		w.idx = idx;
		w.val = val;
		reg_batch.push_back(w);
		if (idx == REG_RLE_MODE)
			rle_now = val[0];
		if (idx == REG_HAS_ALPHA)
			alpha_now = val[0];
	endtask

	// hold bytes back until every span is out, then let the block settle
	task automatic wait_idle();
		byte_valid <= 1'b0;
		forever begin
			@(negedge clk);
			if (spans_waiting == 0)
				break;
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	// register writes go back to back with valid held high
	task automatic flush_regs();
		wait_idle();
		foreach (reg_batch[i]) begin
			cfg_valid <= 1'b1;
			cfg_index <= reg_batch[i].idx;
			cfg_data <= reg_batch[i].val;
			do @(negedge clk); while (!cfg_ready);
			@(posedge clk);
			regs_written++;
		end
		cfg_valid <= 1'b0;
		reg_batch.delete();
	endtask

	task automatic pick_settings();
		logic [15:0] cols;
		case ($urandom_range(0, 5))
			0: cols = 16'($urandom_range(0, 3));  // narrow, behaves as four
			1: cols = 16'd4;
			2: cols = 16'($urandom_range(5, 12));
			3: cols = 16'hFFFF;
			4: cols = 16'($urandom_range(13, 300));
			default: cols = 16'($urandom_range(0, 65535));
		endcase
		queue_reg(REG_COLUMNS, cols);
		// rows stay well above any row the stream can reach here
		queue_reg(REG_ROWS, ($urandom_range(0, 1) == 0) ? 16'hFFFF
			: 16'($urandom_range(16'h4000, 16'hFFFE)));
		queue_reg(REG_RLE_MODE, {15'($urandom), ($urandom_range(0, 3) != 0)});
		queue_reg(REG_HAS_ALPHA, {15'($urandom), 1'($urandom_range(0, 1))});
		queue_reg(REG_TOP_DOWN, {15'($urandom), 1'($urandom_range(0, 1))});
	endtask

	// mostly whole packets with random content, some noise and cut packets
	task automatic send_stream(input int budget);
		int sent, count, total, psize;
		logic run;
		sent = 0;
		psize = alpha_now ? 4 : 3;
		while (sent < budget) begin
			if (!rle_now) begin
				for (int k = 0; k < psize; k++)
					send_byte(rand_byte());
				sent += psize;
			end else if ($urandom_range(0, 9) == 0) begin
				send_byte(8'($urandom_range(0, 255)));
				sent++;
			end else begin
				run = 1'($urandom_range(0, 1));
				if (run)
					count = ($urandom_range(0, 3) == 0) ? 128 : $urandom_range(1, 128);
				else
					count = $urandom_range(1, 5);
				send_byte({run, 7'(count - 1)});
				sent++;
				total = (run ? 1 : count) * psize;
				if ($urandom_range(0, 9) == 0)
					total = $urandom_range(0, total - 1);
				for (int k = 0; k < total; k++)
					send_byte(rand_byte());
				sent += total;
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, no idling
		set_idling(IDLE_NONE);
		queue_reg(REG_ROWS, 16'hFFFF);
		queue_reg(REG_COLUMNS, 16'h0000);   // zero width behaves as four
		queue_reg(REG_RLE_MODE, 16'd0);
		queue_reg(REG_HAS_ALPHA, 16'd0);
		queue_reg(REG_TOP_DOWN, 16'd0);
		flush_regs();
		// uncompressed 24-bit extremes, bottom-up rows
		send_byte(8'h00); send_byte(8'h00); send_byte(8'h00);
		send_byte(8'hFF); send_byte(8'hFF); send_byte(8'hFF);

		queue_reg(REG_RLE_MODE, 16'd1);
		queue_reg(REG_HAS_ALPHA, 16'd1);
		queue_reg(REG_TOP_DOWN, 16'd1);
		flush_regs();
		// longest repeat packet, wraps over many narrow rows
		send_byte(8'hFF);
		send_byte(8'h12); send_byte(8'h34); send_byte(8'h56); send_byte(8'h78);
		// longest literal packet, first pixel only
		send_byte(8'h7F);
		send_byte(8'h01); send_byte(8'h02); send_byte(8'h03); send_byte(8'h04);

		// mode switch in the middle of the literal packet
		queue_reg(REG_RLE_MODE, 16'd0);
		queue_reg(REG_HAS_ALPHA, 16'd0);
		flush_regs();
		send_byte(8'hA0); send_byte(8'hA1); send_byte(8'hA2);

		// back to run-length: literal resumes; pixel size shrinks mid-pixel
		queue_reg(REG_RLE_MODE, 16'd1);
		queue_reg(REG_HAS_ALPHA, 16'd1);
		flush_regs();
		send_byte(8'hB0); send_byte(8'hB1); send_byte(8'hB2);
		queue_reg(REG_HAS_ALPHA, 16'd0);
		flush_regs();
		send_byte(8'hB3);

		// random part, a new setting and idling pattern per phase
		for (int p = 0; p < RAND_PHASES; p++) begin
			set_idling(idle_mode_t'(p % 4));
			pick_settings();
			flush_regs();
			send_stream(PHASE_BYTES);
		end

		// close the image: height zero makes the current row the last one,
		// later bytes must be dropped
		set_idling(IDLE_BOTH);
		queue_reg(REG_COLUMNS, 16'd4);
		queue_reg(REG_ROWS, 16'd0);
		queue_reg(REG_RLE_MODE, 16'd0);
		queue_reg(REG_HAS_ALPHA, 16'd0);
		queue_reg(REG_TOP_DOWN, 16'd0);
		flush_regs();
		for (int k = 0; k < 24; k++)
			send_byte(rand_byte());

		// drain
		byte_valid <= 1'b0;
		forever begin
			@(negedge clk);
			if (spans_waiting == 0)
				break;
		end
		repeat (DRAIN) @(posedge clk);

		$display("sent %0d pixel-data bytes and %0d register writes, compared %0d spans",
			bytes_sent, regs_written, spans_checked);
		$display("covered both modes, both pixel sizes, both row orders and widths 0 to 65535");
		if (mismatch_count == 0 && spans_waiting == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("%0d mismatches, %0d spans never seen", mismatch_count, spans_waiting);
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

[sim.f]
hw/rtl/trpd_pkg.sv
hw/rtl/trpd_span_unit.sv
hw/rtl/tga_rle_pixel_decoder.sv
hw/rtl/trpd_checker.sv
test/tga_span_checker.sv
test/tga_rle_pixel_decoder_tb.sv
